// ----- hw/rtl/lwpt_pkg.sv -----
package lwpt_pkg;

  // Field widths
  localparam int ANGLE_W         = 16;
  localparam int COORD_W         = 24;
  localparam int LEN_W           = 23;
  localparam int ROT_W           = 10;
  localparam int NUM_LEGS        = 6;
  localparam int CORNERS_PER_LEG = 4;
  localparam int LEG_W           = 3;
  localparam int CORNER_W        = 2;
  localparam int REG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = NUM_LEGS * ROT_W;

  // Datapath widths: Q1.16 trig, Q8.16 operands, exact products
  localparam int TRIG_W = 18;
  localparam int OPD_W  = 25;
  localparam int PROD_W = TRIG_W + OPD_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - 16;

  // Pose queue
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [LEG_W-1:0]    LAST_LEG    = 3'(NUM_LEGS - 1);
  localparam logic [CORNER_W-1:0] LAST_CORNER = 2'(CORNERS_PER_LEG - 1);

  localparam logic signed [ACC_W-1:0] RND_POS = 44'sd32768;
  localparam logic signed [ACC_W-1:0] RND_NEG = 44'sd32767;
  localparam logic signed [RND_W-1:0] COORD_HI = 28'sd8388607;
  localparam logic signed [RND_W-1:0] COORD_LO = -28'sd8388608;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_HALF_SPAN_X   = 3'd0,
    REG_SPAN_Y        = 3'd1,
    REG_BODY_RADIUS   = 3'd2,
    REG_MOUNT_ANGLE   = 3'd3,
    REG_LEG_ROTATIONS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [LEN_W-1:0]      half_span_x;
    logic [LEN_W-1:0]      span_y;
    logic [LEN_W-1:0]      body_radius;
    logic [ANGLE_W-1:0]    mount_angle;
    logic [CFG_DATA_W-1:0] leg_rotations;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]        body_angle;
    logic signed [COORD_W-1:0] body_x;
    logic signed [COORD_W-1:0] body_y;
  } pose_t;

  typedef struct packed {
    logic  valid;
    pose_t pose;
  } pose_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BODY_TRIG,
    ST_ORIGIN,
    ST_LEG_TRIG,
    ST_CORNER
  } back_state_t;

  // Round Q.16 to nearest integer, ties away from zero
  function automatic logic signed [RND_W-1:0] round_q16(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + (v[ACC_W-1] ? RND_NEG : RND_POS);
    return t[ACC_W-1:16];
  endfunction

  // Clamp to the 24-bit coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_HI) begin
      r = COORD_HI[COORD_W-1:0];
    end else if (v < COORD_LO) begin
      r = COORD_LO[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/lwpt_ifs.sv -----
interface lwpt_pose_if;
  logic                                valid;
  logic                                ready;
  logic [lwpt_pkg::ANGLE_W-1:0]        body_angle;
  logic signed [lwpt_pkg::COORD_W-1:0] body_x;
  logic signed [lwpt_pkg::COORD_W-1:0] body_y;

  modport source(output valid, body_angle, body_x, body_y, input ready);
  modport sink(input valid, body_angle, body_x, body_y, output ready);
endinterface

interface lwpt_corner_if;
  logic                                valid;
  logic                                ready;
  logic [lwpt_pkg::LEG_W-1:0]          leg_index;
  logic [lwpt_pkg::CORNER_W-1:0]       corner_index;
  logic signed [lwpt_pkg::COORD_W-1:0] point_x;
  logic signed [lwpt_pkg::COORD_W-1:0] point_y;
  logic                                last;

  modport source(output valid, leg_index, corner_index, point_x, point_y, last, input ready);
  modport sink(input valid, leg_index, corner_index, point_x, point_y, last, output ready);
endinterface

// ----- hw/rtl/leg_workspace_pose_transform_unit.sv -----
// Leg workspace pose transform.
// A body pose (heading as a fraction of a turn, x and y in signed Q8.16)
// enters on the pose channel; 24 corner transactions leave on the corner
// channel, legs 0 to 5 and corners 0 to 3 in order, with last set on the
// final one. Geometry comes from the configuration port; it must be written
// while the block is idle, which the block itself does not enforce.
// Each pose needs sixteen sine evaluations on the shared iterative sine
// unit, and two origin products and 24 corners on the single multiplier.
// A two-entry pose queue takes further poses while one is in work, and a
// registered output holds a corner while the receiver stalls; the work
// pauses only when a new corner is ready and the output is still occupied.
// Reset clears the configuration registers to zero, empties the queue and
// drops any pose in progress.
module leg_workspace_pose_transform_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [lwpt_pkg::REG_INDEX_W-1:0]     cfg_index,
  input  logic [lwpt_pkg::CFG_DATA_W-1:0]      cfg_data,
  lwpt_pose_if.sink                            pose,
  lwpt_corner_if.source                        corner
);
  import lwpt_pkg::*;

  cfg_t      cfg;
  pose_req_t pose_req;
  logic      pose_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HALF_SPAN_X:   cfg.half_span_x   <= cfg_data[LEN_W-1:0];
        REG_SPAN_Y:        cfg.span_y        <= cfg_data[LEN_W-1:0];
        REG_BODY_RADIUS:   cfg.body_radius   <= cfg_data[LEN_W-1:0];
        REG_MOUNT_ANGLE:   cfg.mount_angle   <= cfg_data[ANGLE_W-1:0];
        REG_LEG_ROTATIONS: cfg.leg_rotations <= cfg_data;
        default: ;
      endcase
    end
  end

  lwpt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pose       (pose),
    .pose_req   (pose_req),
    .pose_ready (pose_ready)
  );

  lwpt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pose_req   (pose_req),
    .pose_ready (pose_ready),
    .corner     (corner)
  );

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    corner.valid && corner.last |->
      corner.leg_index == LAST_LEG && corner.corner_index == LAST_CORNER)
    else $error("last flag on a corner other than the final one");

  a_leg_range: assert property (@(posedge clk) disable iff (rst)
    corner.valid |-> corner.leg_index <= LAST_LEG)
    else $error("leg index out of range");

  a_reset_clears: assert property (@(posedge clk) rst |=> !corner.valid)
    else $error("corner valid after reset");

endmodule

// ----- hw/rtl/lwpt_front.sv -----
module lwpt_front (
  input  logic                clk,
  input  logic                rst,
  lwpt_pose_if.sink           pose,
  output lwpt_pkg::pose_req_t pose_req,
  input  logic                pose_ready
);
  import lwpt_pkg::*;

  pose_t                 fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  push;
  logic                  pop;

  assign pose.ready     = (count != FIFO_CNT_W'(FIFO_DEPTH));
  assign push           = pose.valid && pose.ready;
  assign pop            = pose_req.valid && pose_ready;
  assign pose_req.valid = (count != '0);
  assign pose_req.pose  = fifo_mem[rd_ptr];

  // Track queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming pose
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{body_angle: pose.body_angle, body_x: pose.body_x,
                            body_y: pose.body_y};
    end
  end

endmodule

// ----- hw/rtl/lwpt_sine.sv -----
module lwpt_sine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lwpt_pkg::ANGLE_W-1:0]        angle,
  output logic                                done,
  output logic signed [lwpt_pkg::TRIG_W-1:0]  result
);
  import lwpt_pkg::*;

  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] RECIP_72 = 33'(((64'd1 << 39) + 64'd71) / 64'd72);
  localparam logic [32:0] RECIP_42 = 33'(((64'd1 << 38) + 64'd41) / 64'd42);
  localparam logic [32:0] RECIP_20 = 33'(((64'd1 << 37) + 64'd19) / 64'd20);
  localparam logic [32:0] RECIP_6  = 33'(((64'd1 << 35) + 64'd5) / 64'd6);
  localparam logic [30:0] ONE_Q30  = 31'h40000000;
  localparam logic [3:0]  LAST_STEP = 4'd9;
  localparam logic [18:0] SIN_CAP  = 19'd65536;

  logic        busy;
  logic [3:0]  step;
  logic        negate;
  logic [14:0] f;
  logic [30:0] x;
  logic [31:0] x2;
  logic [31:0] v;
  logic [30:0] t;
  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [64:0] mul_p;
  logic [18:0] q_raw;
  logic [18:0] q_cap;

  // Select operands for the Horner step
  always_comb begin
    mul_a = {17'd0, f};
    mul_b = HALF_PI_Q30;
    case (step)
      4'd0:    begin mul_a = {17'd0, f};  mul_b = HALF_PI_Q30;   end
      4'd1:    begin mul_a = {1'b0, x};   mul_b = {2'd0, x};     end
      4'd2:    begin mul_a = x2;          mul_b = RECIP_72;      end
      4'd4:    begin mul_a = v;           mul_b = RECIP_42;      end
      4'd6:    begin mul_a = v;           mul_b = RECIP_20;      end
      4'd8:    begin mul_a = v;           mul_b = RECIP_6;       end
      4'd9:    begin mul_a = {1'b0, x};   mul_b = {2'd0, t};     end
      default: begin mul_a = x2;          mul_b = {2'd0, t};     end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign q_raw = 19'((33'(mul_p[61:30]) + 33'd8192) >> 14);
  assign q_cap = (q_raw > SIN_CAP) ? SIN_CAP : q_raw;

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // Fold the angle and carry the series terms
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      negate <= angle[15];
      f      <= angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    end else if (busy) begin
      case (step)
        4'd0: x  <= mul_p[44:14];
        4'd1: x2 <= mul_p[61:30];
        4'd2: t  <= ONE_Q30 - 31'(mul_p[64:39]);
        4'd4: t  <= ONE_Q30 - 31'(mul_p[64:38]);
        4'd6: t  <= ONE_Q30 - 31'(mul_p[64:37]);
        4'd8: t  <= ONE_Q30 - 31'(mul_p[64:35]);
        4'd9: result <= negate ? -$signed(q_cap[TRIG_W-1:0]) : $signed(q_cap[TRIG_W-1:0]);
        default: v <= mul_p[61:30];
      endcase
    end
  end

endmodule

// ----- hw/rtl/lwpt_back.sv -----
module lwpt_back (
  input  logic                clk,
  input  logic                rst,
  input  lwpt_pkg::cfg_t      cfg,
  input  lwpt_pkg::pose_req_t pose_req,
  output logic                pose_ready,
  lwpt_corner_if.source       corner
);
  import lwpt_pkg::*;

  localparam logic [3:0] CORNER_STEPS = 4'd8;
  localparam logic [3:0] ORIGIN_STEPS = 4'd2;

  back_state_t state, state_next;
  logic [1:0]          k, k_next;
  logic [LEG_W-1:0]    leg, leg_next;
  logic [CORNER_W-1:0] cor, cor_next;
  logic [3:0]          step, step_next;
  logic                sin_wait, sin_wait_next;
  logic                sin_start;
  logic                sin_done;
  logic [ANGLE_W-1:0]  sin_angle;
  logic signed [TRIG_W-1:0] sin_result;
  logic                out_free;
  logic                out_load;
  logic                out_valid;

  pose_t                     pose_r;
  logic signed [TRIG_W-1:0]  cb, sb, cm, sm, cr, sr;
  logic signed [COORD_W-1:0] oc, os, lx, ly, wx;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [TRIG_W-1:0]  mul_a;
  logic signed [OPD_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   lin_sum;
  logic signed [RND_W-1:0]   rnd_sum;
  logic signed [RND_W-1:0]   rnd_prod;
  logic signed [OPD_W-1:0]   offset;
  logic signed [COORD_W-1:0] coord;
  logic signed [OPD_W-1:0]   radius, px, py, ox, oy, ox_base;
  logic [ANGLE_W-1:0]        rot;

  lwpt_sine u_sine (
    .clk    (clk),
    .rst    (rst),
    .start  (sin_start),
    .angle  (sin_angle),
    .done   (sin_done),
    .result (sin_result)
  );

  // Leg geometry
  assign radius = $signed({2'b00, cfg.body_radius});
  assign px     = cor[1] ? $signed({2'b00, cfg.half_span_x}) : -$signed({2'b00, cfg.half_span_x});
  assign py     = cor[0] ? $signed({2'b00, cfg.span_y}) : '0;
  assign rot    = {cfg.leg_rotations[leg*ROT_W +: ROT_W], 6'd0};

  always_comb begin
    case (leg) inside
      3'd0, 3'd1: begin ox_base = OPD_W'(oc); oy = OPD_W'(os);   end
      3'd2, 3'd3: begin ox_base = radius;     oy = '0;           end
      default:    begin ox_base = OPD_W'(oc); oy = -OPD_W'(os);  end
    endcase
    ox = leg[0] ? ox_base : -ox_base;
  end

  // Pick the angle for the sine unit
  always_comb begin
    sin_angle = pose_r.body_angle;
    if (state == ST_LEG_TRIG) begin
      sin_angle = (k == 2'd0) ? rot + QUARTER_TURN : rot;
    end else begin
      case (k)
        2'd0:    sin_angle = pose_r.body_angle + QUARTER_TURN;
        2'd1:    sin_angle = pose_r.body_angle;
        2'd2:    sin_angle = cfg.mount_angle + QUARTER_TURN;
        default: sin_angle = cfg.mount_angle;
      endcase
    end
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = cr;
    mul_b = px;
    if (state == ST_ORIGIN) begin
      mul_a = (step == 4'd0) ? cm : sm;
      mul_b = radius;
    end else begin
      case (step)
        4'd1:    begin mul_a = sr; mul_b = py;          end
        4'd2:    begin mul_a = sr; mul_b = px;          end
        4'd3:    begin mul_a = cr; mul_b = py;          end
        4'd4:    begin mul_a = cb; mul_b = OPD_W'(lx);  end
        4'd5:    begin mul_a = sb; mul_b = OPD_W'(ly);  end
        4'd6:    begin mul_a = sb; mul_b = OPD_W'(lx);  end
        4'd7:    begin mul_a = cb; mul_b = OPD_W'(ly);  end
        default: begin mul_a = cr; mul_b = px;          end
      endcase
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign prod_x = ACC_W'(prod);

  // Combine the product pair, round, offset and clamp
  always_comb begin
    case (step)
      4'd2:    begin lin_sum = acc - prod_x; offset = ox;                    end
      4'd4:    begin lin_sum = acc + prod_x; offset = oy;                    end
      4'd6:    begin lin_sum = acc - prod_x; offset = OPD_W'(pose_r.body_x); end
      default: begin lin_sum = acc + prod_x; offset = OPD_W'(pose_r.body_y); end
    endcase
    rnd_sum = round_q16(lin_sum);
    coord   = sat_coord(rnd_sum + RND_W'(offset));
  end

  assign rnd_prod = round_q16(prod_x);
  assign out_free = !out_valid || corner.ready;
  assign out_load = (state == ST_CORNER) && (step == CORNER_STEPS) && out_free;

  // Next state and control
  always_comb begin
    state_next    = state;
    k_next        = k;
    leg_next      = leg;
    cor_next      = cor;
    step_next     = step;
    sin_wait_next = sin_wait;
    sin_start     = 1'b0;
    pose_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pose_ready = 1'b1;
        if (pose_req.valid) begin
          state_next = ST_BODY_TRIG;
          k_next     = '0;
        end
      end
      ST_BODY_TRIG, ST_LEG_TRIG: begin
        if (!sin_wait) begin
          sin_start     = 1'b1;
          sin_wait_next = 1'b1;
        end else if (sin_done) begin
          sin_wait_next = 1'b0;
          k_next        = k + 1'b1;
          if (state == ST_BODY_TRIG && k == 2'd3) begin
            state_next = ST_ORIGIN;
            step_next  = '0;
          end else if (state == ST_LEG_TRIG && k == 2'd1) begin
            state_next = ST_CORNER;
            step_next  = '0;
            cor_next   = '0;
          end
        end
      end
      ST_ORIGIN: begin
        step_next = step + 1'b1;
        if (step == ORIGIN_STEPS) begin
          state_next = ST_LEG_TRIG;
          leg_next   = '0;
          k_next     = '0;
        end
      end
      ST_CORNER: begin
        if (step != CORNER_STEPS) begin
          step_next = step + 1'b1;
        end else if (out_free) begin
          step_next = '0;
          cor_next  = cor + 1'b1;
          if (cor == LAST_CORNER) begin
            if (leg == LAST_LEG) begin
              state_next = ST_IDLE;
            end else begin
              state_next = ST_LEG_TRIG;
              leg_next   = leg + 1'b1;
              k_next     = '0;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      leg       <= '0;
      cor       <= '0;
      step      <= '0;
      sin_wait  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      k        <= k_next;
      leg      <= leg_next;
      cor      <= cor_next;
      step     <= step_next;
      sin_wait <= sin_wait_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (corner.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pose_req.valid) begin
      pose_r <= pose_req.pose;
    end
    if (sin_wait && sin_done) begin
      if (state == ST_BODY_TRIG) begin
        case (k)
          2'd0:    cb <= sin_result;
          2'd1:    sb <= sin_result;
          2'd2:    cm <= sin_result;
          default: sm <= sin_result;
        endcase
      end else if (k == 2'd0) begin
        cr <= sin_result;
      end else begin
        sr <= sin_result;
      end
    end
    // Hold the product while the finished corner waits for the output
    if (!(state == ST_CORNER && step == CORNER_STEPS)) begin
      prod <= mul_p;
    end
    if (state == ST_ORIGIN) begin
      if (step == 4'd1) begin
        oc <= rnd_prod[COORD_W-1:0];
      end
      if (step == 4'd2) begin
        os <= rnd_prod[COORD_W-1:0];
      end
    end
    if (state == ST_CORNER) begin
      case (step)
        4'd1, 4'd3, 4'd5, 4'd7: acc <= prod_x;
        4'd2:    lx <= coord;
        4'd4:    ly <= coord;
        4'd6:    wx <= coord;
        default: ;
      endcase
    end
    if (out_load) begin
      corner.leg_index    <= leg;
      corner.corner_index <= cor;
      corner.point_x      <= wx;
      corner.point_y      <= coord;
      corner.last         <= (leg == LAST_LEG) && (cor == LAST_CORNER);
    end
  end

  assign corner.valid = out_valid;

endmodule

// ----- verif/tb_leg_workspace_pose_transform_unit.sv -----
module tb_leg_workspace_pose_transform_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lwpt_pkg::*;

  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned HALF_PI  = 64'd1686629713;
  localparam longint          PT_MAX   = 8388607;
  localparam longint          PT_MIN   = -8388608;
  localparam int              CYCLE_LIMIT = 3000000;
  localparam int              LONG_HOLD   = 2000;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [LEG_W-1:0]          leg;
    logic [CORNER_W-1:0]       cor;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last;
  } corner_pt_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [REG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lwpt_pose_if   pose_ch();
  lwpt_corner_if corner_ch();

  leg_workspace_pose_transform_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pose      (pose_ch),
    .corner    (corner_ch)
  );

  // Shadow copy of the geometry registers
  logic [LEN_W-1:0]      geo_half_x;
  logic [LEN_W-1:0]      geo_span_y;
  logic [LEN_W-1:0]      geo_radius;
  logic [ANGLE_W-1:0]    geo_mount;
  logic [CFG_DATA_W-1:0] geo_rots;

  pose_t      pending_poses[$];
  corner_pt_t expected_corners[$];
  int         fail_count;
  int         cycle_count;
  int         send_gap;
  int         recv_gap;
  int         hold_left;
  logic       long_hold_req;
  logic       no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quarter-wave sine in Q1.16, Horner series evaluated in Q30
  function automatic longint sine_q16(logic [ANGLE_W-1:0] ang);
    longint unsigned f, x, x2, t, s, q;
    f = ang[13:0];
    if (ang[14]) f = 16384 - f;
    x  = (f * HALF_PI) >> 14;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    q  = (s + 8192) >> 14;
    if (q > 65536) q = 65536;
    return ang[15] ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint cosine_q16(logic [ANGLE_W-1:0] ang);
    return sine_q16(ang + QUARTER_TURN);
  endfunction

  // Q.16 to integer, nearest, ties away from zero
  function automatic longint round_half_away(longint v);
    if (v >= 0) return (v + 32768) >>> 16;
    return -((-v + 32768) >>> 16);
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > PT_MAX) return PT_MAX;
    if (v < PT_MIN) return PT_MIN;
    return v;
  endfunction

  // Work out all 24 world corners for one pose
  function automatic void predict_corners(pose_t p);
    longint cb, sb, r, oc, os, hx, hy, cr, sr, ox, oy, lx, ly, wx, wy, cx, cy;
    logic [ANGLE_W-1:0] rot;
    corner_pt_t c;
    cb = cosine_q16(p.body_angle);
    sb = sine_q16(p.body_angle);
    r  = longint'(geo_radius);
    oc = round_half_away(r * cosine_q16(geo_mount));
    os = round_half_away(r * sine_q16(geo_mount));
    hx = longint'(geo_half_x);
    hy = longint'(geo_span_y);
    for (int leg = 0; leg < NUM_LEGS; leg++) begin
      rot = {geo_rots[leg*ROT_W +: ROT_W], 6'd0};
      cr = cosine_q16(rot);
      sr = sine_q16(rot);
      if (leg < 2) begin
        ox = oc; oy = os;
      end else if (leg < 4) begin
        ox = r; oy = 0;
      end else begin
        ox = oc; oy = -os;
      end
      if (leg % 2 == 0) ox = -ox;
      for (int k = 0; k < CORNERS_PER_LEG; k++) begin
        cx = k[1] ? hx : -hx;
        cy = k[0] ? hy : 0;
        lx = clamp_coord(round_half_away(cr * cx - sr * cy) + ox);
        ly = clamp_coord(round_half_away(sr * cx + cr * cy) + oy);
        wx = clamp_coord(round_half_away(cb * lx - sb * ly) + longint'(p.body_x));
        wy = clamp_coord(round_half_away(sb * lx + cb * ly) + longint'(p.body_y));
        c.leg  = LEG_W'(leg);
        c.cor  = CORNER_W'(k);
        c.px   = wx[COORD_W-1:0];
        c.py   = wy[COORD_W-1:0];
        c.last = (c.leg == LAST_LEG) && (c.cor == LAST_CORNER);
        expected_corners = {expected_corners, c};
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pose driver: hold while stalled, otherwise advance through the queue
  always @(posedge clk) begin
    pose_t p;
    if (rst) begin
      pose_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (pose_ch.valid && pose_ch.ready) begin
        p.body_angle = pose_ch.body_angle;
        p.body_x     = pose_ch.body_x;
        p.body_y     = pose_ch.body_y;
        predict_corners(p);
      end
      if (!(pose_ch.valid && !pose_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          pose_ch.valid <= 1'b0;
        end else if (pending_poses.size() > 0) begin
          p = pending_poses.pop_front();
          pose_ch.body_angle <= p.body_angle;
          pose_ch.body_x     <= p.body_x;
          pose_ch.body_y     <= p.body_y;
          pose_ch.valid      <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          pose_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Corner monitor: check each transaction against the oldest expectation
  always @(posedge clk) begin
    corner_pt_t e;
    int gap;
    if (rst) begin
      corner_ch.ready <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
    end else begin
      if (corner_ch.valid && corner_ch.ready) begin
        if (expected_corners.size() == 0) begin
          $error("corner transaction with nothing expected");
          fail_count++;
        end else begin
          e = expected_corners.pop_front();
          if (corner_ch.leg_index !== e.leg) begin
            $error("leg_index: expected %0d, got %0d", e.leg, corner_ch.leg_index);
            fail_count++;
          end
          if (corner_ch.corner_index !== e.cor) begin
            $error("corner_index: expected %0d, got %0d", e.cor, corner_ch.corner_index);
            fail_count++;
          end
          if (corner_ch.point_x !== e.px) begin
            $error("point_x: expected %0d, got %0d", e.px, corner_ch.point_x);
            fail_count++;
          end
          if (corner_ch.point_y !== e.py) begin
            $error("point_y: expected %0d, got %0d", e.py, corner_ch.point_y);
            fail_count++;
          end
          if (corner_ch.last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, corner_ch.last);
            fail_count++;
          end
        end
      end
      if (long_hold_req) begin
        hold_left <= LONG_HOLD;
        corner_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        corner_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        corner_ch.ready <= 1'b0;
      end else begin
        gap = pick_gap();
        recv_gap <= gap;
        corner_ch.ready <= (gap == 0);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Register write, mirrored into the shadow copy with the kept width
  task automatic write_reg(logic [REG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HALF_SPAN_X:   geo_half_x = val[LEN_W-1:0];
      REG_SPAN_Y:        geo_span_y = val[LEN_W-1:0];
      REG_BODY_RADIUS:   geo_radius = val[LEN_W-1:0];
      REG_MOUNT_ANGLE:   geo_mount  = val[ANGLE_W-1:0];
      REG_LEG_ROTATIONS: geo_rots   = val;
      default: ;
    endcase
  endtask

  task automatic write_geometry(logic [LEN_W-1:0] hx, logic [LEN_W-1:0] sy,
                                logic [LEN_W-1:0] rad, logic [ANGLE_W-1:0] ma,
                                logic [CFG_DATA_W-1:0] rots);
    write_reg(REG_HALF_SPAN_X, CFG_DATA_W'(hx));
    write_reg(REG_SPAN_Y, CFG_DATA_W'(sy));
    write_reg(REG_BODY_RADIUS, CFG_DATA_W'(rad));
    write_reg(REG_MOUNT_ANGLE, CFG_DATA_W'(ma));
    write_reg(REG_LEG_ROTATIONS, rots);
  endtask

  // Wait until every queued pose has gone and every corner has come back
  task automatic drain();
    while (pending_poses.size() != 0 || expected_corners.size() != 0 || pose_ch.valid)
      @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_rots();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return LEN_W'($urandom_range(0, 32'h60000));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'sd0;
      3: return COORD_W'($urandom_range(0, 32'h80000)) - 24'sh40000;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.body_angle = ANGLE_W'($urandom);
    p.body_x     = rand_coord();
    p.body_y     = rand_coord();
    return p;
  endfunction

  task automatic queue_pose(logic [ANGLE_W-1:0] ang, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y);
    pose_t p;
    p.body_angle = ang;
    p.body_x = x;
    p.body_y = y;
    pending_poses = {pending_poses, p};
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_HALF_SPAN_X;
    cfg_data = '0;
    pose_ch.valid = 1'b0;
    pose_ch.body_angle = '0;
    pose_ch.body_x = '0;
    pose_ch.body_y = '0;
    corner_ch.ready = 1'b0;
    long_hold_req = 1'b0;
    no_idle = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    geo_half_x = '0;
    geo_span_y = '0;
    geo_radius = '0;
    geo_mount  = '0;
    geo_rots   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Registers at reset: every corner collapses onto the body position
    queue_pose(16'h0000, 24'sh7FFFFF, -24'sh800000);
    queue_pose(16'hFFFF, -24'sd1, 24'sd0);
    drain();

    // Typical geometry, headings on each quadrant edge and in between
    write_geometry(23'h8000, 23'h10000, 23'h20000, 16'h2000,
                   {10'd512, 10'd256, 10'd768, 10'd1023, 10'd128, 10'd0});
    queue_pose(16'h0000, 24'sd0, 24'sd0);
    queue_pose(16'h4000, 24'sh10000, -24'sh10000);
    queue_pose(16'h8000, -24'sd1, 24'sd1);
    queue_pose(16'hC000, 24'sh123456, -24'sh345678);
    queue_pose(16'hFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_pose(16'h2000, -24'sh800000, -24'sh800000);
    queue_pose(16'h1555, 24'sh0ABCDE, 24'sh0FEDCB);
    drain();

    // Oversized values keep only their low bits; spare indexes do nothing
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(REG_INDEX_W'(i), rand_rots());
    write_reg(REG_HALF_SPAN_X, {37'h1F_FFFF_FFFF, 23'h4000});
    write_reg(REG_SPAN_Y, {37'h15_5555_5555, 23'h8000});
    write_reg(REG_BODY_RADIUS, {37'h0A_AAAA_AAAA, 23'h18000});
    write_reg(REG_MOUNT_ANGLE, {44'hFFF_FFFF_FFFF, 16'h1000});
    queue_pose(16'h3000, 24'sh001000, 24'sh002000);
    queue_pose(16'h9000, -24'sh004000, 24'sh7FF000);
    drain();

    // Largest geometry, then a mixed one: body-frame and world saturation
    write_geometry('1, '1, '1, 16'hFFFF, '1);
    queue_pose(16'h0000, 24'sh7FFFFF, 24'sh7FFFFF);
    queue_pose(16'h6000, -24'sh800000, 24'sh7FFFFF);
    queue_pose(16'hE000, 24'sd0, -24'sh800000);
    drain();
    write_geometry('1, '0, 23'h7F0000, 16'h4000, '0);
    queue_pose(16'h8000, -24'sh800000, 24'sd0);
    queue_pose(16'hA5A5, 24'sh5A5A5A, -24'sh5A5A5A);
    drain();

    // Random phases, geometry changed between them while idle
    for (int ph = 0; ph < 8; ph++) begin
      write_geometry(rand_len(), rand_len(), rand_len(), ANGLE_W'($urandom), rand_rots());
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 55; n++) pending_poses = {pending_poses, rand_pose()};
      // Stall the output for a long stretch so the pose queue backs up
      if (ph == 1) begin
        repeat (20) @(posedge clk);
        long_hold_req <= 1'b1;
        @(posedge clk);
        long_hold_req <= 1'b0;
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (500) @(posedge clk);
    if (expected_corners.size() != 0) begin
      $error("%0d corner transactions never arrived", expected_corners.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
